// ===== rtl/core/sase_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sase_pkg
// Shared types and constants of the six-axis event scaler.
// ----------------------------------------------------------------------------
package sase_pkg;

  localparam int AxisCountDef = 6;
  localparam int ValW         = 16;
  localparam int OutW         = 10;
  localparam int NumAxesOut   = 6;
  localparam int TransAxes    = 3;
  localparam int AxisSelW     = 3;
  localparam int CfgAddrW     = 2;
  localparam int InDataW      = 48;
  localparam int OutDataW     = 72;
  localparam int DiffW        = ValW + 1;
  localparam int ProdW        = 28;
  localparam int DivNW        = ProdW - 1;
  localparam int DivDW        = DiffW + 1;
  localparam int ScaleHalf    = 500;
  localparam int ScaleSpan    = 1000;
  localparam int LevelW       = 2;
  localparam int LevelMax     = 2;

  localparam logic [ValW-1:0]        KeyBase   = 16'd256;
  localparam logic signed [ValW-1:0] KeyPress  = 16'sd1;
  localparam logic signed [ValW-1:0] CfgMinRst = -16'sd500;
  localparam logic signed [ValW-1:0] CfgMaxRst = 16'sd500;

  typedef enum logic [ValW-1:0] {
    EV_SYN = 16'd0,
    EV_KEY = 16'd1,
    EV_REL = 16'd2,
    EV_ABS = 16'd3,
    EV_MSC = 16'd4
  } ev_type_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_TRANS_MIN = 2'd0,
    CFG_TRANS_MAX = 2'd1,
    CFG_ROT_MIN   = 2'd2,
    CFG_ROT_MAX   = 2'd3
  } cfg_reg_e;

  typedef enum logic [6:0] {
    SEQ_IDLE  = 7'b0000001,
    SEQ_LOAD  = 7'b0000010,
    SEQ_PREP  = 7'b0000100,
    SEQ_SIGN  = 7'b0001000,
    SEQ_DIV   = 7'b0010000,
    SEQ_STORE = 7'b0100000,
    SEQ_DONE  = 7'b1000000
  } seq_state_e;

  typedef struct packed {
    logic signed [ValW-1:0] trans_min;
    logic signed [ValW-1:0] trans_max;
    logic signed [ValW-1:0] rot_min;
    logic signed [ValW-1:0] rot_max;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic take;
  } seq_ctrl_t;

  typedef struct packed {
    logic busy;
    logic valid;
  } seq_stat_t;

  typedef logic [NumAxesOut-1:0][OutW-1:0] axis_vec_t;
  typedef logic [1:0][LevelW-1:0]          level_vec_t;

endpackage
`default_nettype wire

// ===== rtl/core/sase_event_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sase_event_regs
// Event decode, axis and button state, range registers.
// ----------------------------------------------------------------------------
module sase_event_regs #(
  parameter int AxisCount = sase_pkg::AxisCountDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                ev_valid_i,
  input  logic [sase_pkg::ValW-1:0]           ev_type_i,
  input  logic [sase_pkg::ValW-1:0]           ev_code_i,
  input  logic signed [sase_pkg::ValW-1:0]    ev_value_i,
  input  logic                                cfg_we_i,
  input  logic [sase_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [sase_pkg::ValW-1:0]           cfg_data_i,
  output sase_pkg::cfg_t                      cfg_o,
  input  logic [sase_pkg::AxisSelW-1:0]       rd_idx_i,
  output logic signed [sase_pkg::ValW-1:0]    rd_raw_o,
  output logic [1:0]                          btn_toggle_o,
  output sase_pkg::level_vec_t                btn_level_o
);
  import sase_pkg::*;

  localparam int IdxW = (AxisCount > 1) ? $clog2(AxisCount) : 1;

  logic signed [ValW-1:0] axis_raw_q [AxisCount];
  logic [1:0]             toggle_q, toggle_d;
  level_vec_t             level_q, level_d;
  cfg_t                   cfg_q, cfg_d;
  logic                   is_axis, is_key;
  logic                   btn;
  logic [LevelW-1:0]      lvl;

  assign is_axis = ev_valid_i && (ev_type_i == EV_REL || ev_type_i == EV_ABS)
                   && (ev_code_i < ValW'(AxisCount));
  assign is_key  = ev_valid_i && (ev_type_i == EV_KEY)
                   && (ev_code_i[ValW-1:1] == KeyBase[ValW-1:1]);
  assign btn     = ev_code_i[0];

  always_comb begin
    if (ev_value_i < 0) begin
      lvl = '0;
    end else if (ev_value_i > ValW'(LevelMax)) begin
      lvl = LevelW'(LevelMax);
    end else begin
      lvl = ev_value_i[LevelW-1:0];
    end
  end

  always_comb begin
    toggle_d = toggle_q;
    level_d  = level_q;
    if (is_key) begin
      level_d[btn] = lvl;
      if (ev_value_i == KeyPress) begin
        toggle_d[btn] = ~toggle_q[btn];
      end
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_TRANS_MIN: cfg_d.trans_min = cfg_data_i;
        CFG_TRANS_MAX: cfg_d.trans_max = cfg_data_i;
        CFG_ROT_MIN:   cfg_d.rot_min   = cfg_data_i;
        CFG_ROT_MAX:   cfg_d.rot_max   = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AxisCount; i++) begin
        axis_raw_q[i] <= '0;
      end
      toggle_q        <= '0;
      level_q         <= '0;
      cfg_q.trans_min <= CfgMinRst;
      cfg_q.trans_max <= CfgMaxRst;
      cfg_q.rot_min   <= CfgMinRst;
      cfg_q.rot_max   <= CfgMaxRst;
    end else begin
      if (is_axis) begin
        axis_raw_q[ev_code_i[IdxW-1:0]] <= ev_value_i;
      end
      toggle_q <= toggle_d;
      level_q  <= level_d;
      cfg_q    <= cfg_d;
    end
  end

  always_comb begin
    rd_raw_o = '0;
    if ({1'b0, rd_idx_i} < (AxisSelW + 1)'(AxisCount)) begin
      rd_raw_o = axis_raw_q[rd_idx_i[IdxW-1:0]];
    end
  end

  assign cfg_o        = cfg_q;
  assign btn_toggle_o = toggle_q;
  assign btn_level_o  = level_q;

endmodule
`default_nettype wire

// ===== rtl/core/sase_serial_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sase_serial_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sase_serial_div #(
  parameter int NumW = sase_pkg::DivNW,
  parameter int DenW = sase_pkg::DivDW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] dividend_i,
  input  logic [DenW-1:0] divisor_i,
  output logic            done_o,
  output logic [NumW-1:0] quotient_o
);
  import sase_pkg::*;

  localparam int CntW = (NumW > 1) ? $clog2(NumW) : 1;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] dvd_q, dvd_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   rem_sh;
  logic            ge;

  assign rem_sh = {rem_q, dvd_q[NumW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW - 1);
      dvd_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DenW'(rem_sh - {1'b0, den_q}) : rem_sh[DenW-1:0];
      dvd_d = {dvd_q[NumW-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule
`default_nettype wire

// ===== rtl/core/sase_axis_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sase_axis_seq
// Walks the six axes, forms the rounded scale fraction, runs the divider.
// ----------------------------------------------------------------------------
module sase_axis_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sase_pkg::seq_ctrl_t               ctrl_i,
  output sase_pkg::seq_stat_t               stat_o,
  input  sase_pkg::cfg_t                    cfg_i,
  output logic [sase_pkg::AxisSelW-1:0]     rd_idx_o,
  input  logic signed [sase_pkg::ValW-1:0]  rd_raw_i,
  output sase_pkg::axis_vec_t               axes_o
);
  import sase_pkg::*;

  seq_state_e             state_q, state_d;
  logic [AxisSelW-1:0]    axis_q, axis_d;
  logic [DiffW-1:0]       a_q, a_d, b_q, b_d;
  logic [ProdW-1:0]       n_q, n_d;
  logic                   zero_q, zero_d, neg_q, neg_d;
  axis_vec_t              axes_q, axes_d;
  logic signed [ValW-1:0] lo, hi;
  logic [ProdW-1:0]       a_ext, b_ext, n_adj;
  logic [DiffW-1:0]       b_abs;
  logic                   div_start, div_done;
  logic [DivNW-1:0]       quot;
  logic [OutW:0]          val_w;
  logic [OutW-1:0]        val;

  assign lo    = (axis_q < AxisSelW'(TransAxes)) ? cfg_i.trans_min : cfg_i.rot_min;
  assign hi    = (axis_q < AxisSelW'(TransAxes)) ? cfg_i.trans_max : cfg_i.rot_max;
  assign a_ext = {{(ProdW - DiffW){a_q[DiffW-1]}}, a_q};
  assign b_ext = {{(ProdW - DiffW){b_q[DiffW-1]}}, b_q};
  assign n_adj = b_q[DiffW-1] ? ProdW'(-n_q) : n_q;
  assign b_abs = b_q[DiffW-1] ? DiffW'(-b_q) : b_q;

  assign div_start = (state_q == SEQ_SIGN) && !n_adj[ProdW-1];

  sase_serial_div #(
    .NumW (DivNW),
    .DenW (DivDW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_adj[DivNW-1:0]),
    .divisor_i  ({b_abs, 1'b0}),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_comb begin
    if (zero_q) begin
      val_w = '0;
    end else if (neg_q) begin
      val_w = (OutW + 1)'(ScaleHalf);
    end else if (quot > DivNW'(ScaleSpan)) begin
      val_w = -((OutW + 1)'(ScaleHalf));
    end else begin
      val_w = (OutW + 1)'(ScaleHalf) - {1'b0, quot[OutW-1:0]};
    end
    val = val_w[OutW-1:0];
  end

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    a_d     = a_q;
    b_d     = b_q;
    n_d     = n_q;
    zero_d  = zero_q;
    neg_d   = neg_q;
    axes_d  = axes_q;
    case (state_q)
      SEQ_IDLE: begin
        if (ctrl_i.start) begin
          axis_d  = '0;
          state_d = SEQ_LOAD;
        end
      end
      SEQ_LOAD: begin
        a_d     = DiffW'($signed({rd_raw_i[ValW-1], rd_raw_i}) - $signed({lo[ValW-1], lo}));
        b_d     = DiffW'($signed({hi[ValW-1], hi}) - $signed({lo[ValW-1], lo}));
        zero_d  = 1'b0;
        neg_d   = 1'b0;
        state_d = SEQ_PREP;
      end
      SEQ_PREP: begin
        if (b_q == '0) begin
          zero_d  = 1'b1;
          state_d = SEQ_STORE;
        end else begin
          // 2000*a + b, rounding offset folded into the dividend
          n_d     = (a_ext << 11) - (a_ext << 5) - (a_ext << 4) + b_ext;
          state_d = SEQ_SIGN;
        end
      end
      SEQ_SIGN: begin
        if (n_adj[ProdW-1]) begin
          neg_d   = 1'b1;
          state_d = SEQ_STORE;
        end else begin
          state_d = SEQ_DIV;
        end
      end
      SEQ_DIV: begin
        if (div_done) begin
          state_d = SEQ_STORE;
        end
      end
      SEQ_STORE: begin
        axes_d[axis_q] = val;
        if (axis_q == AxisSelW'(NumAxesOut - 1)) begin
          state_d = SEQ_DONE;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = SEQ_LOAD;
        end
      end
      SEQ_DONE: begin
        if (ctrl_i.take) begin
          state_d = SEQ_IDLE;
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      axis_q  <= '0;
      zero_q  <= 1'b0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      zero_q  <= zero_d;
      neg_q   <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    n_q    <= n_d;
    axes_q <= axes_d;
  end

  assign stat_o.busy  = (state_q != SEQ_IDLE);
  assign stat_o.valid = (state_q == SEQ_DONE);
  assign rd_idx_o     = axis_q;
  assign axes_o       = axes_q;

endmodule
`default_nettype wire

// ===== rtl/core/six_axis_event_scaler_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// six_axis_event_scaler_top
// Input events in, one scaled six-axis report per batch out.
//
// s_axis carries one input event per beat: type, code and signed value in
// tdata, the end-of-batch flag in tlast. cfg writes the four range
// registers by index; it is always ready. m_axis carries one report per
// batch: six scaled axes, two toggle latches and two key levels.
// An event without tlast is taken and the next can follow at once. A beat
// with tlast starts the report: each axis runs through the shared
// bit-serial divider (one quotient bit per cycle, 27 bits), and the report
// appears on m_axis once all six axes are stored; an axis skips the
// divider when its range is empty or its rounded dividend is negative.
// s_axis_tready is low while the report is computed. The report waits in
// the output register while m_axis_tready is low; further events are
// accepted meanwhile, and a following report is held back until the
// register frees up.
// Reset clears the axis values, buttons and output valid flag and loads the
// ranges with -500..500.
// ----------------------------------------------------------------------------
module six_axis_event_scaler_top #(
  parameter int AXIS_COUNT = sase_pkg::AxisCountDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // event_type [15:0], event_code [31:16], event_value [47:32]
  input  logic [sase_pkg::InDataW-1:0]      s_axis_tdata_i,
  input  logic                              s_axis_tlast_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // trans_x [9:0], trans_y [19:10], trans_z [29:20], rot_x [39:30],
  // rot_y [49:40], rot_z [59:50], button1_toggle [60], button2_toggle [61],
  // button1_raw [63:62], button2_raw [65:64], zero [71:66]
  output logic [sase_pkg::OutDataW-1:0]     m_axis_tdata_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sase_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [sase_pkg::ValW-1:0]         cfg_data_i
);
  import sase_pkg::*;

  seq_ctrl_t              seq_ctrl;
  seq_stat_t              seq_stat;
  cfg_t                   cfg;
  logic [AxisSelW-1:0]    rd_idx;
  logic signed [ValW-1:0] rd_raw;
  axis_vec_t              axes;
  logic [1:0]             toggles;
  level_vec_t             levels;
  logic                   in_beat;
  logic                   out_valid_q, out_valid_d;
  logic [OutDataW-1:0]    out_data_q, out_data_d;

  assign s_axis_tready_o = !seq_stat.busy;
  assign cfg_ready_o     = 1'b1;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  assign seq_ctrl.start = in_beat && s_axis_tlast_i;
  assign seq_ctrl.take  = seq_stat.valid && (!out_valid_q || m_axis_tready_i);

  sase_event_regs #(
    .AxisCount (AXIS_COUNT)
  ) u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ev_valid_i   (in_beat),
    .ev_type_i    (s_axis_tdata_i[ValW-1:0]),
    .ev_code_i    (s_axis_tdata_i[2*ValW-1:ValW]),
    .ev_value_i   (s_axis_tdata_i[3*ValW-1:2*ValW]),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .cfg_o        (cfg),
    .rd_idx_i     (rd_idx),
    .rd_raw_o     (rd_raw),
    .btn_toggle_o (toggles),
    .btn_level_o  (levels)
  );

  sase_axis_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (seq_ctrl),
    .stat_o   (seq_stat),
    .cfg_i    (cfg),
    .rd_idx_o (rd_idx),
    .rd_raw_i (rd_raw),
    .axes_o   (axes)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (seq_ctrl.take) begin
      out_valid_d = 1'b1;
      out_data_d  = OutDataW'({levels, toggles, axes});
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
`default_nettype wire

// ===== rtl/core/sase_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sase_checker
// Port-level checks of the six-axis event scaler, bound to the top level.
// ----------------------------------------------------------------------------
module sase_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tlast_i,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_o,
  input  logic [sase_pkg::OutDataW-1:0] m_axis_tdata_o,
  input  logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i
);
  import sase_pkg::*;

  logic range_ok;

  always_comb begin
    logic signed [OutW-1:0] v;
    range_ok = 1'b1;
    for (int i = 0; i < NumAxesOut; i++) begin
      v = m_axis_tdata_o[i*OutW +: OutW];
      if (v > OutW'(ScaleHalf) || v < -(OutW'(ScaleHalf))) begin
        range_ok = 1'b0;
      end
    end
    if (m_axis_tdata_o[63:62] > LevelW'(LevelMax) ||
        m_axis_tdata_o[65:64] > LevelW'(LevelMax)) begin
      range_ok = 1'b0;
    end
  end

  // batch end starts the report and blocks the input
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input still ready after batch-end beat");

  // plain events never stall the input
  a_ready_after_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tlast_i |=> s_axis_tready_o)
    else $error("input stalled after plain event");

  // every reported axis and key level inside its range
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> range_ok)
    else $error("report field out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled report changed");

endmodule

bind six_axis_event_scaler_top sase_checker u_sase_checker (.*);
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the six-axis event scaler.
//
// A queue of events, filled phase by phase, feeds a burst driver on s_axis.
// Each phase after the first starts with new axis ranges, written while the block is idle.
// A built-in scaler follows every accepted beat and predicts each report.
// Every m_axis beat is checked field by field against the oldest prediction.
// The receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
  import sase_pkg::*;

  localparam int AxisCount = AxisCountDef;
  localparam int DrainCycles = 250;

  typedef struct packed {
    logic [ValW-1:0]        ev_type;
    logic [ValW-1:0]        ev_code;
    logic signed [ValW-1:0] ev_value;
    logic                   batch_end;
  } event_t;

  typedef struct packed {
    logic [NumAxesOut-1:0][OutW-1:0] axis;
    logic [1:0]                      toggle;
    logic [1:0][LevelW-1:0]          level;
  } report_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic [InDataW-1:0]   ev_data = '0;
  logic                 ev_last = 1'b0;
  logic                 ev_valid = 1'b0;
  logic                 ev_ready;
  logic [OutDataW-1:0]  rep_data;
  logic                 rep_valid;
  logic                 rep_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgAddrW-1:0]  cfg_addr = '0;
  logic [ValW-1:0]      cfg_data = '0;

  event_t  pending_events[$];
  report_t expected_reports[$];
  int      mismatch_count = 0;

  // scaler state and ranges as the block should hold them
  logic signed [ValW-1:0]   axis_pos[AxisCount];
  logic                     toggle_latch[2];
  logic [LevelW-1:0]        key_level[2];
  logic signed [ValW-1:0]   trans_lo, trans_hi, rot_lo, rot_hi;

  six_axis_event_scaler_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (ev_data),
    .s_axis_tlast_i  (ev_last),
    .s_axis_tvalid_i (ev_valid),
    .s_axis_tready_o (ev_ready),
    .m_axis_tdata_o  (rep_data),
    .m_axis_tvalid_o (rep_valid),
    .m_axis_tready_i (rep_ready),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(64'd16_000_000);
    $display("tb_top: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [OutW-1:0] scale_position(logic signed [ValW-1:0] pos,
                                                     logic signed [ValW-1:0] lo,
                                                     logic signed [ValW-1:0] hi);
    longint num, den, quo, res;
    num = 1000 * (longint'(pos) - longint'(lo));
    den = longint'(hi) - longint'(lo);
    if (den == 0) begin
      quo = 500;
    end else begin
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      num = 2 * num + den;
      den = 2 * den;
      quo = num / den;
      if ((num % den) != 0 && num < 0) quo = quo - 1;
    end
    res = 500 - quo;
    if (res > 500) res = 500;
    if (res < -500) res = -500;
    return res[OutW-1:0];
  endfunction

  task automatic track_event(event_t ev);
    report_t r;
    int      b;
    if (ev.ev_type == EV_REL || ev.ev_type == EV_ABS) begin
      if (ev.ev_code < AxisCount) axis_pos[ev.ev_code] = ev.ev_value;
    end else if (ev.ev_type == EV_KEY) begin
      if (ev.ev_code == KeyBase || ev.ev_code == KeyBase + 16'd1) begin
        b = ev.ev_code[0];
        if (ev.ev_value < 0) key_level[b] = '0;
        else if (ev.ev_value > LevelMax) key_level[b] = LevelW'(LevelMax);
        else key_level[b] = ev.ev_value[LevelW-1:0];
        if (ev.ev_value == KeyPress) toggle_latch[b] = ~toggle_latch[b];
      end
    end
    if (ev.batch_end) begin
      for (int i = 0; i < NumAxesOut; i++) begin
        if (i < TransAxes) r.axis[i] = scale_position(axis_pos[i], trans_lo, trans_hi);
        else r.axis[i] = scale_position(axis_pos[i], rot_lo, rot_hi);
      end
      r.toggle = {toggle_latch[1], toggle_latch[0]};
      r.level[0] = key_level[0];
      r.level[1] = key_level[1];
      expected_reports.push_back(r);
    end
  endtask

  task automatic note_mismatch(string msg);
    mismatch_count++;
    $display("tb_top: mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [OutW-1:0] got, logic [OutW-1:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic check_report(logic [OutDataW-1:0] d);
    report_t want;
    string   axis_names[NumAxesOut];
    axis_names = '{"trans_x", "trans_y", "trans_z", "rot_x", "rot_y", "rot_z"};
    if (expected_reports.size() == 0) begin
      note_mismatch("report beat with nothing expected");
    end else begin
      want = expected_reports.pop_front();
      for (int i = 0; i < NumAxesOut; i++)
        check_field(axis_names[i], d[i*OutW +: OutW], want.axis[i]);
      check_field("button1_toggle", OutW'(d[60]), OutW'(want.toggle[0]));
      check_field("button2_toggle", OutW'(d[61]), OutW'(want.toggle[1]));
      check_field("button1_raw", OutW'(d[63:62]), OutW'(want.level[0]));
      check_field("button2_raw", OutW'(d[65:64]), OutW'(want.level[1]));
    end
  endtask

  // report check first, then the event and range beats of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rep_valid && rep_ready) check_report(rep_data);
      if (ev_valid && ev_ready)
        track_event({ev_data[15:0], ev_data[31:16], ev_data[47:32], ev_last});
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_e'(cfg_addr))
          CFG_TRANS_MIN: trans_lo = cfg_data;
          CFG_TRANS_MAX: trans_hi = cfg_data;
          CFG_ROT_MIN:   rot_lo = cfg_data;
          CFG_ROT_MAX:   rot_hi = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // ------------------------------------------------------------ event driver

  int     gap_left = 0;
  int     burst_left = 0;
  event_t next_ev;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid <= 1'b0;
      ev_last  <= 1'b0;
      ev_data  <= '0;
    end else if (!ev_valid || ev_ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        ev_valid <= 1'b0;
      end else if (pending_events.size() != 0) begin
        next_ev = pending_events.pop_front();
        ev_data  <= {next_ev.ev_value, next_ev.ev_code, next_ev.ev_type};
        ev_last  <= next_ev.batch_end;
        ev_valid <= 1'b1;
        if (burst_left <= 1) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left <= $urandom_range(100, 200);
            gap_left   <= 0;
          end else begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        ev_valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------ report sink

  int ready_run = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_ready <= 1'b0;
      ready_run <= 0;
    end else if (ready_run == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          rep_ready <= 1'b1;
          ready_run <= $urandom_range(40, 400);
        end
        1, 2: begin
          rep_ready <= 1'($urandom_range(0, 1));
          ready_run <= $urandom_range(1, 6);
        end
        default: begin
          rep_ready <= 1'b0;
          ready_run <= $urandom_range(1, 16);
        end
      endcase
    end else begin
      ready_run <= ready_run - 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic event_t make_event(logic [ValW-1:0] t, logic [ValW-1:0] c,
                                        logic signed [ValW-1:0] v, logic last);
    event_t ev;
    ev.ev_type = t;
    ev.ev_code = c;
    ev.ev_value = v;
    ev.batch_end = last;
    return ev;
  endfunction

  function automatic logic signed [ValW-1:0] pick_position(int lo, int hi);
    int a, b, v;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = a + int'($urandom_range(0, b - a));
      4, 5:       v = int'($signed(ValW'($urandom)));
      6:          v = $urandom_range(0, 1) ? 32767 : -32768;
      7:          v = $urandom_range(0, 1) ? lo : hi;
      8:          v = $urandom_range(0, 1) ? a - int'($urandom_range(1, 20))
                                           : b + int'($urandom_range(1, 20));
      default:    v = (a + b) / 2 + int'($urandom_range(0, 2)) - 1;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[ValW-1:0];
  endfunction

  function automatic event_t axis_event(logic last);
    logic [ValW-1:0] code;
    logic [ValW-1:0] kind;
    kind = $urandom_range(0, 1) ? EV_REL : EV_ABS;
    code = ($urandom_range(0, 9) == 0) ? ValW'($urandom_range(AxisCount, 65535))
                                       : ValW'($urandom_range(0, AxisCount - 1));
    if (code < TransAxes)
      return make_event(kind, code, pick_position(trans_lo, trans_hi), last);
    return make_event(kind, code, pick_position(rot_lo, rot_hi), last);
  endfunction

  function automatic event_t key_event(logic last);
    logic [ValW-1:0]        code;
    logic signed [ValW-1:0] v;
    code = ($urandom_range(0, 9) == 0) ? ValW'($urandom)
                                       : KeyBase + ValW'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = KeyPress;
      5, 6:          v = 16'sd0;
      7:             v = 16'sd2;
      8:             v = ValW'($urandom);
      default:       v = -$signed(ValW'($urandom_range(1, 32768)));
    endcase
    return make_event(EV_KEY, code, v, last);
  endfunction

  task automatic queue_batches(int quota);
    int     done_count, n, pick;
    bit     close_on_last;
    event_t ev;
    done_count = 0;
    while (done_count < quota) begin
      if ($urandom_range(0, 9) < 8) begin
        n = $urandom_range(0, 7);
        close_on_last = (n != 0) && ($urandom_range(0, 2) == 0);
        for (int i = 0; i < n; i++) begin
          pick = $urandom_range(0, 9);
          if (pick < 7) ev = axis_event(close_on_last && i == n - 1);
          else if (pick < 9) ev = key_event(close_on_last && i == n - 1);
          else ev = make_event(EV_MSC, ValW'($urandom_range(0, 7)), ValW'($urandom),
                               close_on_last && i == n - 1);
          pending_events.push_back(ev);
          done_count++;
        end
        if (!close_on_last) begin
          pending_events.push_back(make_event(EV_SYN, '0, '0, 1'b1));
          done_count++;
        end
      end else begin
        // noise: any type, code and value
        ev = make_event($urandom_range(0, 1) ? ValW'($urandom) : ValW'($urandom_range(0, 7)),
                        ValW'($urandom), ValW'($urandom), $urandom_range(0, 3) == 0);
        pending_events.push_back(ev);
        done_count++;
      end
    end
  endtask

  task automatic queue_directed();
    pending_events.push_back(make_event(EV_ABS, 16'd0, 16'sd32767, 1'b0));
    pending_events.push_back(make_event(EV_REL, 16'd1, -16'sd32768, 1'b0));
    pending_events.push_back(make_event(EV_ABS, 16'd2, 16'sd500, 1'b0));
    pending_events.push_back(make_event(EV_REL, 16'd3, -16'sd500, 1'b0));
    pending_events.push_back(make_event(EV_ABS, 16'd4, 16'sd0, 1'b0));
    pending_events.push_back(make_event(EV_ABS, 16'd5, 16'sd250, 1'b1));
    pending_events.push_back(make_event(EV_KEY, KeyBase, KeyPress, 1'b0));
    pending_events.push_back(make_event(EV_KEY, KeyBase + 16'd1, 16'sd2, 1'b1));
    pending_events.push_back(make_event(EV_KEY, KeyBase, -16'sd1, 1'b0));
    pending_events.push_back(make_event(EV_KEY, KeyBase + 16'd1, 16'sd32767, 1'b0));
    pending_events.push_back(make_event(EV_KEY, KeyBase + 16'd1, KeyPress, 1'b1));
    // other keys, axis codes past the last axis, other and unknown event types
    pending_events.push_back(make_event(EV_KEY, KeyBase + 16'd2, KeyPress, 1'b0));
    pending_events.push_back(make_event(EV_KEY, KeyBase - 16'd1, KeyPress, 1'b0));
    pending_events.push_back(make_event(EV_ABS, 16'd6, 16'sd123, 1'b0));
    pending_events.push_back(make_event(EV_REL, 16'hFFFF, -16'sd7, 1'b0));
    pending_events.push_back(make_event(EV_SYN, 16'd0, 16'sd0, 1'b1));
    pending_events.push_back(make_event(EV_MSC, 16'd4, 16'sd9, 1'b1));
    pending_events.push_back(make_event(16'hFFFF, 16'd0, 16'sd1000, 1'b1));
    pending_events.push_back(make_event(16'd5, 16'd1, -16'sd1000, 1'b1));
    // just outside the range on both sides
    pending_events.push_back(make_event(EV_REL, 16'd0, -16'sd501, 1'b0));
    pending_events.push_back(make_event(EV_ABS, 16'd1, 16'sd501, 1'b1));
    pending_events.push_back(make_event(EV_KEY, KeyBase, 16'sd0, 1'b1));
    pending_events.push_back(make_event(EV_ABS, 16'd2, -16'sd32768, 1'b0));
    pending_events.push_back(make_event(EV_REL, 16'd3, 16'sd32767, 1'b1));
  endtask

  task automatic write_range(cfg_reg_e idx, logic [ValW-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_ranges(int tmin, int tmax, int rmin, int rmax);
    write_range(CFG_TRANS_MIN, ValW'(tmin));
    write_range(CFG_TRANS_MAX, ValW'(tmax));
    write_range(CFG_ROT_MIN, ValW'(rmin));
    write_range(CFG_ROT_MAX, ValW'(rmax));
  endtask

  task automatic run_until_idle();
    @(negedge clk_i);
    while (pending_events.size() != 0 || ev_valid || expected_reports.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(int quota);
    @(negedge clk_i);
    queue_batches(quota);
    run_until_idle();
  endtask

  initial begin
    for (int i = 0; i < AxisCount; i++) axis_pos[i] = '0;
    toggle_latch = '{1'b0, 1'b0};
    key_level    = '{'0, '0};
    trans_lo = CfgMinRst;
    trans_hi = CfgMaxRst;
    rot_lo   = CfgMinRst;
    rot_hi   = CfgMaxRst;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    @(negedge clk_i);
    queue_directed();
    run_phase(300);

    set_ranges(-32768, 32767, 32767, -32768);
    run_phase(320);
    // empty ranges
    set_ranges(100, 100, -32768, -32768);
    run_phase(320);
    // narrow ranges that hit rounding halves
    set_ranges(0, 3, -8, 8);
    run_phase(320);
    set_ranges(int'($signed(ValW'($urandom))), int'($signed(ValW'($urandom))),
               int'($signed(ValW'($urandom))), int'($signed(ValW'($urandom))));
    run_phase(320);
    set_ranges(500, -500, 32767, 32767);
    run_phase(320);

    if (expected_reports.size() != 0) note_mismatch("reports still expected at end");
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sase_pkg.sv
rtl/core/sase_event_regs.sv
rtl/core/sase_serial_div.sv
rtl/core/sase_axis_seq.sv
rtl/core/six_axis_event_scaler_top.sv
rtl/core/sase_checker.sv
test/tb_top.sv
